/* rtl/ke2u_pkg.sv */
package ke2u_pkg;

   // Virtual key codes
   localparam logic [7:0] KeyPageUp   = 8'h21;
   localparam logic [7:0] KeyPageDown = 8'h22;
   localparam logic [7:0] KeyEnd      = 8'h23;
   localparam logic [7:0] KeyHome     = 8'h24;
   localparam logic [7:0] KeyLeft     = 8'h25;
   localparam logic [7:0] KeyUp       = 8'h26;
   localparam logic [7:0] KeyRight    = 8'h27;
   localparam logic [7:0] KeyDown     = 8'h28;
   localparam logic [7:0] KeyDelete   = 8'h2E;
   localparam logic [7:0] KeyImeProc  = 8'hE5;

   localparam logic [7:0] EscByte     = 8'h1B;
   localparam logic [7:0] BracketByte = 8'h5B;  // '['
   localparam logic [7:0] TildeByte   = 8'h7E;  // '~'

   localparam logic [15:0] HighSurFirst = 16'hD800;
   localparam logic [15:0] HighSurLast  = 16'hDBFF;
   localparam logic [15:0] LowSurFirst  = 16'hDC00;
   localparam logic [15:0] LowSurLast   = 16'hDFFF;
   localparam logic [20:0] SuppBase     = 21'h10000;

   localparam logic [7:0] ContMark  = 8'h80;
   localparam logic [7:0] Lead2Mark = 8'hC0;
   localparam logic [7:0] Lead3Mark = 8'hE0;
   localparam logic [7:0] Lead4Mark = 8'hF0;

   localparam int QueueDepth     = 2;
   localparam int QueueAddrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCntWidth  = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic        is_key_event;
      logic        key_down;
      logic [7:0]  key_code;
      logic [15:0] code_unit;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   // One event's byte sequence: bytes[0] goes out first
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic      hit;
      entry_type seq;
   } esc_type;

   function automatic entry_type encode_cp(input logic [20:0] cp);
      entry_type e;
      e = '0;
      if (cp < 21'h80) begin
         e.bytes[0] = {1'b0, cp[6:0]};
         e.last_idx = 2'd0;
      end else if (cp < 21'h800) begin
         e.bytes[0] = Lead2Mark | {3'b000, cp[10:6]};
         e.bytes[1] = ContMark  | {2'b00, cp[5:0]};
         e.last_idx = 2'd1;
      end else if (cp < SuppBase) begin
         e.bytes[0] = Lead3Mark | {4'b0000, cp[15:12]};
         e.bytes[1] = ContMark  | {2'b00, cp[11:6]};
         e.bytes[2] = ContMark  | {2'b00, cp[5:0]};
         e.last_idx = 2'd2;
      end else begin
         e.bytes[0] = Lead4Mark | {5'b00000, cp[20:18]};
         e.bytes[1] = ContMark  | {2'b00, cp[17:12]};
         e.bytes[2] = ContMark  | {2'b00, cp[11:6]};
         e.bytes[3] = ContMark  | {2'b00, cp[5:0]};
         e.last_idx = 2'd3;
      end
      return e;
   endfunction

   function automatic esc_type escape_seq(input logic [7:0] key_code);
      esc_type r;
      r.hit = 1'b1;
      r.seq = '0;
      r.seq.bytes[0] = EscByte;
      r.seq.bytes[1] = BracketByte;
      r.seq.last_idx = 2'd2;
      case (key_code)
         KeyUp:    r.seq.bytes[2] = "A";
         KeyDown:  r.seq.bytes[2] = "B";
         KeyRight: r.seq.bytes[2] = "C";
         KeyLeft:  r.seq.bytes[2] = "D";
         KeyHome:  r.seq.bytes[2] = "H";
         KeyEnd:   r.seq.bytes[2] = "F";
         KeyDelete: begin
            r.seq.bytes[2] = "3";
            r.seq.bytes[3] = TildeByte;
            r.seq.last_idx = 2'd3;
         end
         KeyPageUp: begin
            r.seq.bytes[2] = "5";
            r.seq.bytes[3] = TildeByte;
            r.seq.last_idx = 2'd3;
         end
         KeyPageDown: begin
            r.seq.bytes[2] = "6";
            r.seq.bytes[3] = TildeByte;
            r.seq.last_idx = 2'd3;
         end
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/ke2u_front.sv */
module ke2u_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ke2u_pkg::req_type      req_payload,
   input  ke2u_pkg::q_status_type q_status,
   output logic                   push,
   output ke2u_pkg::entry_type    push_entry
);

   logic [15:0]       held_ff;
   logic [15:0]       held_in;
   logic              accept;
   logic              active;
   logic              is_high;
   logic              is_low;
   logic [20:0]       cp;
   ke2u_pkg::esc_type esc;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign active    = req_payload.is_key_event && req_payload.key_down &&
                      (req_payload.key_code != ke2u_pkg::KeyImeProc);
   assign is_high   = (req_payload.code_unit >= ke2u_pkg::HighSurFirst) &&
                      (req_payload.code_unit <= ke2u_pkg::HighSurLast);
   assign is_low    = (req_payload.code_unit >= ke2u_pkg::LowSurFirst) &&
                      (req_payload.code_unit <= ke2u_pkg::LowSurLast);
   assign esc       = ke2u_pkg::escape_seq(req_payload.key_code);

   always_comb begin
      held_in    = held_ff;
      push       = 1'b0;
      cp         = {5'd0, req_payload.code_unit};
      if (is_low && (held_ff != 16'd0)) begin
         // pair join: offsets of both halves side by side
         cp = ke2u_pkg::SuppBase + {1'b0, held_ff[9:0], req_payload.code_unit[9:0]};
      end
      push_entry = ke2u_pkg::encode_cp(cp);
      if (accept && active) begin
         if (req_payload.code_unit != 16'd0) begin
            if (is_high) begin
               held_in = req_payload.code_unit;
            end else begin
               held_in = 16'd0;
               push    = 1'b1;
            end
         end else begin
            held_in    = 16'd0;
            push       = esc.hit;
            push_entry = esc.seq;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 16'd0;
      end else begin
         held_ff <= held_in;
      end
   end

   a_held_range: assert property (@(posedge clock) disable iff (reset)
      (held_ff == 16'd0) ||
      ((held_ff >= ke2u_pkg::HighSurFirst) && (held_ff <= ke2u_pkg::HighSurLast)))
      else $error("held surrogate out of range");

endmodule

/* rtl/ke2u_queue.sv */
module ke2u_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ke2u_pkg::entry_type    push_entry,
   input  logic                   pop,
   output ke2u_pkg::entry_type    pop_entry,
   output ke2u_pkg::q_status_type q_status
);

   ke2u_pkg::entry_type                      mem_ff [ke2u_pkg::QueueDepth];
   logic [ke2u_pkg::QueueAddrWidth-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [ke2u_pkg::QueueAddrWidth-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [ke2u_pkg::QueueCntWidth-1:0]       count_ff, count_in;

   localparam logic [ke2u_pkg::QueueAddrWidth-1:0] LastAddr =
      ke2u_pkg::QueueAddrWidth'(ke2u_pkg::QueueDepth - 1);
   localparam logic [ke2u_pkg::QueueCntWidth-1:0] FullCount =
      ke2u_pkg::QueueCntWidth'(ke2u_pkg::QueueDepth);

   assign q_status.full  = (count_ff == FullCount);
   assign q_status.empty = (count_ff == '0);
   assign pop_entry      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastAddr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastAddr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("queue count beyond depth");

endmodule

/* rtl/ke2u_back.sv */
module ke2u_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ke2u_pkg::q_status_type q_status,
   input  ke2u_pkg::entry_type    pop_entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ke2u_pkg::rsp_type      rsp_payload
);

   ke2u_pkg::entry_type cur_ff, cur_in;
   logic [1:0]          idx_ff, idx_in;
   logic                busy_ff, busy_in;
   logic                at_last;
   logic                done;

   assign at_last = (idx_ff == cur_ff.last_idx);
   assign done    = busy_ff && rsp_ready && at_last;
   assign pop     = !q_status.empty && (!busy_ff || done);

   assign rsp_valid             = busy_ff;
   assign rsp_payload.out_byte  = cur_ff.bytes[idx_ff];
   assign rsp_payload.last_byte = at_last;

   always_comb begin
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (pop) begin
         cur_in  = pop_entry;
         idx_in  = 2'd0;
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff && rsp_ready) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   a_idx_in_seq: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= cur_ff.last_idx))
      else $error("byte index past end of sequence");

endmodule

/* rtl/key_event_to_utf8_escape_unit.sv */
// Keyboard event to UTF-8 / escape sequence unit.
// req channel (req_valid/req_ready/req_payload): one console input event per
//   item. Key-up, non-key and IME process key events are consumed silently.
// rsp channel (rsp_valid/rsp_ready/rsp_payload): one byte per item; last_byte
//   marks the final byte of the bytes an event produced.
// Front end classifies the event, tracks the held high surrogate and builds
//   the whole 1..4 byte sequence in the cycle the event is accepted; the
//   sequence goes into a two-entry queue.
// Back end pulls a sequence and serializes it, one byte per cycle while
//   rsp_ready is high. The accepting edge writes the queue; when the
//   serializer is free it loads the sequence from the queue and raises
//   rsp_valid, so the first byte comes from the serializer register.
// Flow: the single byte-wide serializer holds the back end until the last
//   byte of a sequence is taken; events with no output take no queue entry.
//   The front keeps taking events while the queue has room.
// Stall: if rsp_ready stays low, the byte holds, the queue fills, and
//   req_ready drops once both queue entries are taken.
// Reset: synchronous, active high; clears the held surrogate, empties the
//   queue and drops rsp_valid. No clearing sweep is needed.
module key_event_to_utf8_escape_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ke2u_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ke2u_pkg::rsp_type rsp_payload
);

   ke2u_pkg::q_status_type q_status;
   ke2u_pkg::entry_type    push_entry;
   ke2u_pkg::entry_type    pop_entry;
   logic                   push;
   logic                   pop;

   ke2u_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   // decouples event intake from byte output
   ke2u_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   ke2u_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

   // Long enough for every event giving four bytes, with every byte held
   // back by the longest stall and every event behind the longest idle gap.
   localparam int CycleLimit = 200000;
   localparam int DrainCycles = 8;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   ke2u_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   ke2u_pkg::rsp_type rsp_payload;

   // Predictor state: the high surrogate waiting for its partner, 0 when none.
   logic [15:0]       held_hi = '0;
   // Bytes still owed by the unit, oldest first.
   ke2u_pkg::rsp_type owed_bytes[$];

   bit idle_on  = 1'b1;
   bit stall_on = 1'b1;

   int errors          = 0;
   int events_taken    = 0;
   int bytes_checked   = 0;
   int pairs_joined    = 0;
   int escapes_emitted = 0;
   int cycle_count     = 0;

   key_event_to_utf8_escape_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: any hang in either handshake ends here.
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("key_event_to_utf8_escape_unit regression: fail");
      $finish;
   end

   // Receiver: ready stalls in random bursts while enabled.
   // Exactly one assignment per pass, and each pass waits on the clock.
   initial begin
      forever begin
         if (stall_on && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   // Work out the bytes one accepted event should produce and queue them.
   function automatic void predict_event(input ke2u_pkg::req_type ev);
      logic [20:0]       cp;
      logic [7:0]        seq [4];
      int                n;
      ke2u_pkg::rsp_type b;
      n = 0;
      // Non-key, key-up and IME process events leave everything untouched
      if (!ev.is_key_event || !ev.key_down || ev.key_code == ke2u_pkg::KeyImeProc)
         return;
      if (ev.code_unit != '0) begin
         if (ev.code_unit >= ke2u_pkg::HighSurFirst &&
             ev.code_unit <= ke2u_pkg::HighSurLast) begin
            // new high surrogate replaces whatever was held
            held_hi = ev.code_unit;
            return;
         end
         if (ev.code_unit >= ke2u_pkg::LowSurFirst &&
             ev.code_unit <= ke2u_pkg::LowSurLast && held_hi != '0) begin
            cp = ke2u_pkg::SuppBase + 21'({held_hi[9:0], ev.code_unit[9:0]});
            pairs_joined++;
         end else begin
            // lone low surrogate or plain unit: encoded on its own
            cp = 21'(ev.code_unit);
         end
         held_hi = '0;
         if (cp < 21'h80) begin
            seq[0] = cp[7:0];
            n = 1;
         end else if (cp < 21'h800) begin
            seq[0] = ke2u_pkg::Lead2Mark | {3'b000, cp[10:6]};
            seq[1] = ke2u_pkg::ContMark | {2'b00, cp[5:0]};
            n = 2;
         end else if (cp < ke2u_pkg::SuppBase) begin
            seq[0] = ke2u_pkg::Lead3Mark | {4'b0000, cp[15:12]};
            seq[1] = ke2u_pkg::ContMark | {2'b00, cp[11:6]};
            seq[2] = ke2u_pkg::ContMark | {2'b00, cp[5:0]};
            n = 3;
         end else begin
            seq[0] = ke2u_pkg::Lead4Mark | {5'b00000, cp[20:18]};
            seq[1] = ke2u_pkg::ContMark | {2'b00, cp[17:12]};
            seq[2] = ke2u_pkg::ContMark | {2'b00, cp[11:6]};
            seq[3] = ke2u_pkg::ContMark | {2'b00, cp[5:0]};
            n = 4;
         end
      end else begin
         // Zero unit: function key. Held surrogate is lost either way.
         held_hi = '0;
         seq[0] = ke2u_pkg::EscByte;
         seq[1] = ke2u_pkg::BracketByte;
         seq[3] = ke2u_pkg::TildeByte;
         n = 3;
         case (ev.key_code)
            ke2u_pkg::KeyUp:       seq[2] = "A";
            ke2u_pkg::KeyDown:     seq[2] = "B";
            ke2u_pkg::KeyRight:    seq[2] = "C";
            ke2u_pkg::KeyLeft:     seq[2] = "D";
            ke2u_pkg::KeyHome:     seq[2] = "H";
            ke2u_pkg::KeyEnd:      seq[2] = "F";
            ke2u_pkg::KeyDelete:   begin seq[2] = "3"; n = 4; end
            ke2u_pkg::KeyPageUp:   begin seq[2] = "5"; n = 4; end
            ke2u_pkg::KeyPageDown: begin seq[2] = "6"; n = 4; end
            default:               n = 0;
         endcase
         if (n != 0) escapes_emitted++;
      end
      for (int k = 0; k < n; k++) begin
         b.out_byte  = seq[k];
         b.last_byte = (k == n - 1);
         owed_bytes.push_back(b);
      end
   endfunction

   // Checker and predictor share one process: at each edge the byte leaving
   // the unit is compared first, then the event entering it is predicted.
   // A byte never leaves in the cycle its event is taken, so the order holds.
   always @(posedge clock) begin
      ke2u_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (owed_bytes.size() == 0) begin
               $error("unexpected byte: out_byte %h last_byte %b",
                      rsp_payload.out_byte, rsp_payload.last_byte);
               errors++;
            end else begin
               want = owed_bytes.pop_front();
               bytes_checked++;
               if (rsp_payload.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, got %h",
                         want.out_byte, rsp_payload.out_byte);
                  errors++;
               end
               if (rsp_payload.last_byte !== want.last_byte) begin
                  $error("last_byte: expected %b, got %b",
                         want.last_byte, rsp_payload.last_byte);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_event(req_payload);
            events_taken++;
         end
      end
   end

   function automatic ke2u_pkg::req_type key_press(input logic [7:0] kc,
                                                   input logic [15:0] cu);
      ke2u_pkg::req_type ev;
      ev.is_key_event = 1'b1;
      ev.key_down     = 1'b1;
      ev.key_code     = kc;
      ev.code_unit    = cu;
      return ev;
   endfunction

   function automatic logic [7:0] nav_key(input int idx);
      case (idx)
         0:       return ke2u_pkg::KeyUp;
         1:       return ke2u_pkg::KeyDown;
         2:       return ke2u_pkg::KeyRight;
         3:       return ke2u_pkg::KeyLeft;
         4:       return ke2u_pkg::KeyHome;
         5:       return ke2u_pkg::KeyEnd;
         6:       return ke2u_pkg::KeyDelete;
         7:       return ke2u_pkg::KeyPageUp;
         default: return ke2u_pkg::KeyPageDown;
      endcase
   endfunction

   // Present one event and hold it until taken. Optional idle burst first.
   task automatic send_event(input ke2u_pkg::req_type ev);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= ev;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stop sending and let every owed byte come out. The first edge lets the
   // predictor take in the last accepted event.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_bytes.size() != 0) @(posedge clock);
   endtask

   task automatic test_ignored_events();
      ke2u_pkg::req_type ev;
      ev = key_press(8'h41, 16'h0041);
      ev.is_key_event = 1'b0;
      send_event(ev);
      ev = key_press(8'hFF, 16'hFFFF);
      ev.key_down = 1'b0;
      send_event(ev);
      // IME key must not disturb a held high surrogate
      send_event(key_press(8'h41, 16'hD800));
      send_event(key_press(ke2u_pkg::KeyImeProc, 16'hDC00));
      send_event(key_press(8'h41, 16'hDFFF));
   endtask

   task automatic test_text_extremes();
      send_event(key_press(8'h41, 16'h007F));
      send_event(key_press(8'h41, 16'h0080));
      send_event(key_press(8'h41, 16'h07FF));
      send_event(key_press(8'h41, 16'h0800));
      send_event(key_press(8'h41, 16'hFFFF));
   endtask

   task automatic test_surrogates();
      // highest pair -> U+10FFFF
      send_event(key_press(8'h00, 16'hDBFF));
      send_event(key_press(8'h00, 16'hDFFF));
      // second high replaces the first
      send_event(key_press(8'h41, 16'hD800));
      send_event(key_press(8'h41, 16'hDBFF));
      send_event(key_press(8'h41, 16'hDC00));
      // plain character drops the held high
      send_event(key_press(8'h41, 16'hD900));
      send_event(key_press(8'h41, 16'h0041));
      // escape key clears the held high, so the low stands alone
      send_event(key_press(8'h41, 16'hD800));
      send_event(key_press(ke2u_pkg::KeyUp, 16'h0000));
      send_event(key_press(8'h41, 16'hDC00));
   endtask

   task automatic test_escape_keys();
      for (int i = 0; i < 9; i++)
         send_event(key_press(nav_key(i), 16'h0000));
      // unmapped function key: nothing out
      send_event(key_press(8'h70, 16'h0000));
   endtask

   // Mostly well-formed typing with random content, plus noise.
   task automatic test_random_events(input int count);
      int                done;
      int                pick;
      logic [7:0]        kc;
      logic [15:0]       hi;
      ke2u_pkg::req_type ev;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 99);
         kc = 8'($urandom_range(0, 255));
         if (kc == ke2u_pkg::KeyImeProc) kc = 8'h41;
         if (pick < 10) begin
            // ignored event, any fields
            ev = ke2u_pkg::req_type'(26'($urandom));
            case ($urandom_range(0, 2))
               0:       ev.is_key_event = 1'b0;
               1:       ev.key_down = 1'b0;
               default: ev.key_code = ke2u_pkg::KeyImeProc;
            endcase
            send_event(ev);
            done++;
         end else if (pick < 30) begin
            hi = 16'($urandom_range(ke2u_pkg::HighSurFirst, ke2u_pkg::HighSurLast));
            send_event(key_press(kc, hi));
            send_event(key_press(kc, 16'($urandom_range(ke2u_pkg::LowSurFirst,
                                                        ke2u_pkg::LowSurLast))));
            done += 2;
         end else if (pick < 45) begin
            if ($urandom_range(0, 4) == 0)
               send_event(key_press(kc, 16'h0000));
            else
               send_event(key_press(nav_key($urandom_range(0, 8)), 16'h0000));
            done++;
         end else if (pick < 75) begin
            case ($urandom_range(0, 2))
               0:       ev = key_press(kc, 16'($urandom_range(1, 'h7F)));
               1:       ev = key_press(kc, 16'($urandom_range('h80, 'h7FF)));
               default: ev = key_press(kc, 16'($urandom_range('h800, 'hFFFF)));
            endcase
            send_event(ev);
            done++;
         end else begin
            // anything a key press can carry, surrogates in any order
            send_event(key_press(8'($urandom_range(0, 255)),
                                 16'($urandom_range(0, 'hFFFF))));
            done++;
         end
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_ignored_events();
      test_text_extremes();
      test_surrogates();
      test_escape_keys();
      test_random_events(30);
      // sender backs off until the unit has caught up
      wait_drained();
      test_random_events(30);
      // final stretch at full rate on both sides
      idle_on  = 1'b0;
      stall_on = 1'b0;
      test_random_events(10);

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      $display("covered %0d events, %0d bytes checked", events_taken, bytes_checked);
      $display("including %0d surrogate pairs and %0d escape sequences",
               pairs_joined, escapes_emitted);
      if (errors == 0 && owed_bytes.size() == 0) begin
         $display("key_event_to_utf8_escape_unit regression: pass");
      end else begin
         $display("key_event_to_utf8_escape_unit regression: fail");
      end
      $finish;
   end

endmodule
